// ===== src/tfr_pkg.sv =====
// Shared types, constants and glyph table of the text framebuffer renderer.
package tfr_pkg;

	// Field widths of the command and result beats
	localparam int OPCODE_W = 3;
	localparam int CHAR_W   = 8;
	localparam int X_W      = 7;
	localparam int Y_W      = 6;
	localparam int BIDX_W   = 10;
	localparam int DATA_W   = 8;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_W_W     = 8;
	localparam int CFG_H_W     = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_HEIGHT = 1'd1;

	localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 8'd128;
	localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 7'd64;

	// Glyph geometry
	localparam int GLYPH_W    = 4;
	localparam int GLYPH_H    = 6;
	localparam int GLYPH_BITS = GLYPH_W * GLYPH_H;
	localparam int GIDX_W     = $clog2(GLYPH_BITS);
	localparam int GLYPHS     = 128;

	// Internal coordinate widths (cover the largest screen and cursor overhang)
	localparam int WEFF_W = 9;
	localparam int HEFF_W = 8;
	localparam int PX_W   = 8;
	localparam int PAGE_W = 4;
	localparam int ROW_W  = PAGE_W + 3;

	// One read-modify-write step per glyph column and page half
	localparam int STEP_W = $clog2(2 * GLYPH_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * GLYPH_W - 1);

	typedef enum logic [OPCODE_W-1:0] {
		OP_DRAW_CHAR  = 3'd0,
		OP_SET_PIXEL  = 3'd1,
		OP_SET_CURSOR = 3'd2,
		OP_CLEAR      = 3'd3,
		OP_READ_BYTE  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CTL_CLEAR,
		CTL_IDLE,
		CTL_RMW_RD,
		CTL_RMW_WR,
		CTL_FETCH,
		CTL_REPLY
	} ctl_state_t;

	typedef struct packed {
		logic              load;
		logic              clr_wr;
		logic              fetch;
		logic              rmw_wr;
		logic              glyph;
		logic [STEP_W-1:0] step;
		logic              reply;
		logic              reply_read;
		logic              advance;
		logic              set_cursor;
	} tfr_cmd_t;

	typedef struct packed {
		logic clr_last;
	} tfr_status_t;

	// 4x6 font, column major, bit 0 is the top row of the first column
	localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPHS] = '{
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f7df,
		24'h000000, 24'h0005c0, 24'h003003, 24'h01f29f,
		24'h0057ca, 24'h012109, 24'h01c5cf, 24'h0000c0,
		24'h011380, 24'h000391, 24'h005085, 24'h004384,
		24'h000210, 24'h004104, 24'h000400, 24'h003118,
		24'h00f45e, 24'h0007c2, 24'h012559, 24'h00a551,
		24'h01f107, 24'h009557, 24'h01d55e, 24'h003159,
		24'h01f55f, 24'h00f557, 24'h000280, 24'h000290,
		24'h011284, 24'h00a28a, 24'h004291, 24'h003541,
		24'h01654e, 24'h01e15e, 24'h00a55f, 24'h01144e,
		24'h00e45f, 24'h01555f, 24'h00515f, 24'h01d54e,
		24'h01f11f, 24'h0117d1, 24'h00f408, 24'h01b11f,
		24'h01041f, 24'h01f19f, 24'h01f39f, 24'h00e44e,
		24'h00215f, 24'h01e64e, 24'h01635f, 24'h009552,
		24'h0017c1, 24'h01f40f, 24'h007607, 24'h01f31f,
		24'h01b11b, 24'h003703, 24'h013559, 24'h01145f,
		24'h008102, 24'h01f451, 24'h002042, 24'h010410,
		24'h000081, 24'h01c59a, 24'h00c49f, 24'h01248c,
		24'h01f48c, 24'h01668c, 24'h005784, 24'h01ea8c,
		24'h01c09f, 24'h000740, 24'h01d810, 24'h01231f,
		24'h0107d1, 24'h01e39e, 24'h01c09e, 24'h00c48c,
		24'h00c4be, 24'h03e48c, 24'h00209c, 24'h00a794,
		24'h0127c2, 24'h01e40e, 24'h00e60e, 24'h01e71e,
		24'h012312, 24'h01ea06, 24'h01679a, 24'h0116c4,
		24'h0007c0, 24'h0046d1, 24'h002184, 24'h01f7df
	};

	// Codes with the top bit set fall back to the first glyph
	function automatic logic [GLYPH_BITS-1:0] glyph_lookup(input logic [CHAR_W-1:0] code);
		return code[CHAR_W-1] ? GLYPH_ROM[0] : GLYPH_ROM[code[CHAR_W-2:0]];
	endfunction

endpackage

// ===== src/tfr_ram.sv =====
// Generic single-port RAM with registered read data.
module tfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on enable, always register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/tfr_controller.sv =====
// Controller state machine of the text framebuffer renderer.
module tfr_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tfr_pkg::OPCODE_W-1:0]  opcode,
	output logic                          busy,
	output tfr_pkg::tfr_cmd_t             cmd,
	input  tfr_pkg::tfr_status_t          status
);

	tfr_pkg::ctl_state_t           state_q, state_d;
	tfr_pkg::op_t                  op_q, op_d;
	logic [tfr_pkg::STEP_W-1:0]    step_q, step_d;
	logic                          clr_reply_q, clr_reply_d;

	// Hold state; sweep the store straight after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfr_pkg::CTL_CLEAR;
			op_q        <= tfr_pkg::OP_CLEAR;
			step_q      <= '0;
			clr_reply_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			op_q        <= op_d;
			step_q      <= step_d;
			clr_reply_q <= clr_reply_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		step_d      = step_q;
		clr_reply_d = clr_reply_q;
		cmd         = '0;
		cmd.glyph   = (op_q == tfr_pkg::OP_DRAW_CHAR);
		cmd.step    = step_q;
		case (state_q)
			tfr_pkg::CTL_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = clr_reply_q ? tfr_pkg::CTL_REPLY : tfr_pkg::CTL_IDLE;
				end
			end
			tfr_pkg::CTL_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					op_d     = tfr_pkg::op_t'(opcode);
					step_d   = '0;
					case (tfr_pkg::op_t'(opcode))
						tfr_pkg::OP_DRAW_CHAR, tfr_pkg::OP_SET_PIXEL: begin
							state_d = tfr_pkg::CTL_RMW_RD;
						end
						tfr_pkg::OP_CLEAR: begin
							state_d     = tfr_pkg::CTL_CLEAR;
							clr_reply_d = 1'b1;
						end
						tfr_pkg::OP_READ_BYTE: begin
							state_d = tfr_pkg::CTL_FETCH;
						end
						default: begin
							state_d = tfr_pkg::CTL_REPLY;
						end
					endcase
				end
			end
			tfr_pkg::CTL_RMW_RD: begin
				state_d = tfr_pkg::CTL_RMW_WR;
			end
			tfr_pkg::CTL_RMW_WR: begin
				cmd.rmw_wr = 1'b1;
				if (cmd.glyph && step_q != tfr_pkg::STEP_LAST) begin
					step_d  = step_q + 1'b1;
					state_d = tfr_pkg::CTL_RMW_RD;
				end else begin
					state_d = tfr_pkg::CTL_REPLY;
				end
			end
			tfr_pkg::CTL_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = tfr_pkg::CTL_REPLY;
			end
			tfr_pkg::CTL_REPLY: begin
				cmd.reply      = 1'b1;
				cmd.reply_read = (op_q == tfr_pkg::OP_READ_BYTE);
				cmd.advance    = (op_q == tfr_pkg::OP_DRAW_CHAR);
				cmd.set_cursor = (op_q == tfr_pkg::OP_SET_CURSOR);
				clr_reply_d    = 1'b0;
				state_d        = tfr_pkg::CTL_IDLE;
			end
			default: begin
				state_d = tfr_pkg::CTL_IDLE;
			end
		endcase
	end

	assign busy = (state_q != tfr_pkg::CTL_IDLE);

endmodule

// ===== src/tfr_datapath.sv =====
// Datapath: configuration, cursor, pixel addressing, framebuffer and result registers.
module tfr_datapath #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tfr_pkg::tfr_cmd_t                cmd,
	output tfr_pkg::tfr_status_t             status,
	input  logic                             cfg_we,
	input  logic [tfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [tfr_pkg::CHAR_W-1:0]       char_code,
	input  logic [tfr_pkg::X_W-1:0]          x_coord,
	input  logic [tfr_pkg::Y_W-1:0]          y_coord,
	input  logic                             pixel_on,
	input  logic [tfr_pkg::BIDX_W-1:0]       byte_index,
	output logic                             done,
	output logic [tfr_pkg::DATA_W-1:0]       read_data,
	output logic [tfr_pkg::X_W-1:0]          cursor_column,
	output logic [tfr_pkg::Y_W-1:0]          cursor_row
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT / 8;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W  = tfr_pkg::PAGE_W + tfr_pkg::WEFF_W + 1;
	localparam int CMP_W  = ((tfr_pkg::BIDX_W > ADDR_W) ? tfr_pkg::BIDX_W : ADDR_W) + 1;

	logic [tfr_pkg::CFG_W_W-1:0]    cfg_w_q;
	logic [tfr_pkg::CFG_H_W-1:0]    cfg_h_q;
	logic [tfr_pkg::X_W-1:0]        cx_q;
	logic [tfr_pkg::Y_W-1:0]        cy_q;
	logic [ADDR_W-1:0]              clr_cnt_q;
	logic                           done_q;
	logic [tfr_pkg::DATA_W-1:0]     read_data_q;
	logic [tfr_pkg::X_W-1:0]        x_q;
	logic [tfr_pkg::Y_W-1:0]        y_q;
	logic                           lit_q;
	logic [tfr_pkg::BIDX_W-1:0]     bidx_q;
	logic [tfr_pkg::GLYPH_BITS-1:0] glyph_q;

	logic [tfr_pkg::WEFF_W-1:0]     w_eff;
	logic [tfr_pkg::HEFF_W-1:0]     h_eff;
	logic [1:0]                     col;
	logic [tfr_pkg::PX_W-1:0]       px;
	logic [tfr_pkg::PAGE_W-1:0]     page;
	logic [IDX_W-1:0]               idx;
	logic [CMP_W-1:0]               bidx_ext;
	logic                           bidx_ok;
	logic [tfr_pkg::DATA_W-1:0]     mask;
	logic [tfr_pkg::DATA_W-1:0]     wval;
	logic [tfr_pkg::DATA_W-1:0]     rdata;
	logic [tfr_pkg::DATA_W-1:0]     new_byte;
	logic                           wr_ok;
	logic                           ram_we;
	logic [ADDR_W-1:0]              ram_addr;
	logic [tfr_pkg::DATA_W-1:0]     ram_wdata;
	logic [tfr_pkg::PX_W-1:0]       nx_raw;
	logic [tfr_pkg::ROW_W-1:0]      ny_raw;
	logic                           wrap_x;
	logic                           wrap_y;
	logic [tfr_pkg::X_W-1:0]        nxt_x;
	logic [tfr_pkg::Y_W-1:0]        nxt_y;

	// Clamp oversized registers to the store geometry
	always_comb begin
		if ({1'b0, cfg_w_q} > tfr_pkg::WEFF_W'(MAX_WIDTH)) begin
			w_eff = tfr_pkg::WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = {1'b0, cfg_w_q};
		end
		if ({1'b0, cfg_h_q} > tfr_pkg::HEFF_W'(MAX_HEIGHT)) begin
			h_eff = tfr_pkg::HEFF_W'(MAX_HEIGHT);
		end else begin
			h_eff = {1'b0, cfg_h_q};
		end
	end

	// Byte position of the current step: glyph column and page half, or the single pixel
	assign col  = cmd.step[tfr_pkg::STEP_W-1:1];
	assign px   = cmd.glyph ? (tfr_pkg::PX_W'(cx_q) + tfr_pkg::PX_W'(col))
		: tfr_pkg::PX_W'(x_q);
	assign page = cmd.glyph
		? (tfr_pkg::PAGE_W'(cy_q[tfr_pkg::Y_W-1:3]) + tfr_pkg::PAGE_W'(cmd.step[0]))
		: tfr_pkg::PAGE_W'(y_q[tfr_pkg::Y_W-1:3]);
	assign idx  = IDX_W'(page) * IDX_W'(w_eff) + IDX_W'(px);

	// Build the bit mask and new bits for the eight rows of this byte
	always_comb begin
		logic [tfr_pkg::ROW_W-1:0]  row;
		logic [tfr_pkg::ROW_W-1:0]  diff;
		logic [tfr_pkg::GIDX_W-1:0] gidx;
		logic                       hit;
		logic                       bitv;
		mask = '0;
		wval = '0;
		for (int b = 0; b < tfr_pkg::DATA_W; b++) begin
			row  = {page, 3'(b)};
			diff = row - tfr_pkg::ROW_W'(cy_q);
			gidx = tfr_pkg::GIDX_W'(col) * tfr_pkg::GIDX_W'(tfr_pkg::GLYPH_H)
				+ tfr_pkg::GIDX_W'(diff[2:0]);
			bitv = 1'b0;
			if (cmd.glyph) begin
				hit = (row >= tfr_pkg::ROW_W'(cy_q))
					&& (diff < tfr_pkg::ROW_W'(tfr_pkg::GLYPH_H));
				if (hit) begin
					bitv = glyph_q[gidx];
				end
			end else begin
				hit  = (row == tfr_pkg::ROW_W'(y_q));
				bitv = lit_q;
			end
			mask[b] = hit && (tfr_pkg::HEFF_W'(row) < h_eff)
				&& (tfr_pkg::WEFF_W'(px) < w_eff);
			wval[b] = bitv;
		end
	end

	assign new_byte = (rdata & ~mask) | (wval & mask);
	assign wr_ok    = (mask != '0) && (idx < IDX_W'(DEPTH));

	// Range check for the read beat
	assign bidx_ext = CMP_W'(bidx_q);
	assign bidx_ok  = bidx_ext < CMP_W'(DEPTH);

	// Store port: clearing sweep, byte fetch or read-modify-write
	always_comb begin
		if (cmd.clr_wr) begin
			ram_addr = clr_cnt_q;
		end else if (cmd.fetch) begin
			ram_addr = bidx_ext[ADDR_W-1:0];
		end else begin
			ram_addr = idx[ADDR_W-1:0];
		end
		ram_we    = cmd.clr_wr || (cmd.rmw_wr && wr_ok);
		ram_wdata = cmd.clr_wr ? '0 : new_byte;
	end

	tfr_ram #(
		.WIDTH (tfr_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (rdata)
	);

	assign status.clr_last = (clr_cnt_q == ADDR_W'(DEPTH - 1));

	// Advance the cursor by one glyph, wrapping the line and then the screen, or load it from a set-cursor command
	assign nx_raw = tfr_pkg::PX_W'(cx_q) + tfr_pkg::PX_W'(tfr_pkg::GLYPH_W);
	assign ny_raw = tfr_pkg::ROW_W'(cy_q) + tfr_pkg::ROW_W'(tfr_pkg::GLYPH_H);
	assign wrap_x = (tfr_pkg::WEFF_W'(nx_raw) + tfr_pkg::WEFF_W'(tfr_pkg::GLYPH_W)) > w_eff;
	assign wrap_y = (tfr_pkg::HEFF_W'(ny_raw) + tfr_pkg::HEFF_W'(tfr_pkg::GLYPH_H)) > h_eff;

	always_comb begin
		nxt_x = cx_q;
		nxt_y = cy_q;
		if (cmd.advance) begin
			if (wrap_x) begin
				nxt_x = '0;
				nxt_y = wrap_y ? '0 : ny_raw[tfr_pkg::Y_W-1:0];
			end else begin
				nxt_x = nx_raw[tfr_pkg::X_W-1:0];
			end
		end else if (cmd.set_cursor) begin
			nxt_x = x_q;
			nxt_y = y_q;
		end
	end

	// Control state: registers, cursor, sweep counter, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q     <= tfr_pkg::WIDTH_RESET;
			cfg_h_q     <= tfr_pkg::HEIGHT_RESET;
			cx_q        <= '0;
			cy_q        <= '0;
			clr_cnt_q   <= '0;
			done_q      <= 1'b0;
			read_data_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tfr_pkg::REG_DISPLAY_WIDTH:  cfg_w_q <= cfg_data;
					tfr_pkg::REG_DISPLAY_HEIGHT: cfg_h_q <= cfg_data[tfr_pkg::CFG_H_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= status.clr_last ? '0 : clr_cnt_q + 1'b1;
			end
			done_q <= cmd.reply;
			if (cmd.reply) begin
				cx_q        <= nxt_x;
				cy_q        <= nxt_y;
				read_data_q <= (cmd.reply_read && bidx_ok) ? rdata : '0;
			end
		end
	end

	// Capture the command beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= x_coord;
			y_q     <= y_coord;
			lit_q   <= pixel_on;
			bidx_q  <= byte_index;
			glyph_q <= tfr_pkg::glyph_lookup(char_code);
		end
	end

	assign done          = done_q;
	assign read_data     = read_data_q;
	assign cursor_column = cx_q;
	assign cursor_row    = cy_q;

endmodule

// ===== src/text_framebuffer_renderer.sv =====
// Top level of the text framebuffer renderer: controller, datapath and checks.
//
// Usage:
//   Commands enter on start while busy is low; opcode picks draw character,
//   set pixel, set cursor, clear or read byte, and the other fields carry
//   the operands. Each command gives one result beat: done is high for one
//   cycle with read_data, cursor_column and cursor_row valid in that cycle.
//   The receiver cannot stall; the result is simply presented once.
//   Steps of each command before its reply state:
//     draw character runs eight read-modify-writes (a read state, then a
//     write state) on the single framebuffer port; set pixel reads and
//     rewrites its byte; read byte fetches the addressed store byte; set
//     cursor and unused opcodes go straight to the reply state; clear sweeps the store (one store byte per cycle).
//   A new command may be accepted in the done cycle.
//   After reset busy stays high while the framebuffer is swept to zero.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and belong between commands.
module text_framebuffer_renderer #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             start,
	output logic                             busy,
	input  logic [tfr_pkg::OPCODE_W-1:0]     opcode,
	input  logic [tfr_pkg::CHAR_W-1:0]       char_code,
	input  logic [tfr_pkg::X_W-1:0]          x_coord,
	input  logic [tfr_pkg::Y_W-1:0]          y_coord,
	input  logic                             pixel_on,
	input  logic [tfr_pkg::BIDX_W-1:0]       byte_index,
	output logic                             done,
	output logic [tfr_pkg::DATA_W-1:0]       read_data,
	output logic [tfr_pkg::X_W-1:0]          cursor_column,
	output logic [tfr_pkg::Y_W-1:0]          cursor_row
);

	tfr_pkg::tfr_cmd_t    cmd;
	tfr_pkg::tfr_status_t status;

	tfr_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	tfr_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.char_code     (char_code),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.pixel_on      (pixel_on),
		.byte_index    (byte_index),
		.done          (done),
		.read_data     (read_data),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row)
	);

`ifndef SYNTHESIS
	// An accepted command always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// The result beat comes with the block ready for the next command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	// One result beat per command, never two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// The cursor moves only together with a result beat
	a_cursor_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(cursor_column) || !$stable(cursor_row)) |-> done)
		else $error("cursor changed without a result beat");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the text framebuffer renderer: directed table, then random commands.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tfr_pkg::*;

	localparam int MAX_W       = 128;
	localparam int MAX_H       = 64;
	localparam int STORE_BYTES = MAX_W * MAX_H / 8;
	localparam int PHASE_ITEMS = 210;
	localparam int PHASES      = 8;

	// Opcodes that the block must treat as no operation
	localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

	// Font, column major, bit 0 is the top row of the left column
	localparam logic [23:0] FONT_BITS [128] = '{
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f7df,
		24'h000000, 24'h0005c0, 24'h003003, 24'h01f29f, 24'h0057ca, 24'h012109, 24'h01c5cf, 24'h0000c0,
		24'h011380, 24'h000391, 24'h005085, 24'h004384, 24'h000210, 24'h004104, 24'h000400, 24'h003118,
		24'h00f45e, 24'h0007c2, 24'h012559, 24'h00a551, 24'h01f107, 24'h009557, 24'h01d55e, 24'h003159,
		24'h01f55f, 24'h00f557, 24'h000280, 24'h000290, 24'h011284, 24'h00a28a, 24'h004291, 24'h003541,
		24'h01654e, 24'h01e15e, 24'h00a55f, 24'h01144e, 24'h00e45f, 24'h01555f, 24'h00515f, 24'h01d54e,
		24'h01f11f, 24'h0117d1, 24'h00f408, 24'h01b11f, 24'h01041f, 24'h01f19f, 24'h01f39f, 24'h00e44e,
		24'h00215f, 24'h01e64e, 24'h01635f, 24'h009552, 24'h0017c1, 24'h01f40f, 24'h007607, 24'h01f31f,
		24'h01b11b, 24'h003703, 24'h013559, 24'h01145f, 24'h008102, 24'h01f451, 24'h002042, 24'h010410,
		24'h000081, 24'h01c59a, 24'h00c49f, 24'h01248c, 24'h01f48c, 24'h01668c, 24'h005784, 24'h01ea8c,
		24'h01c09f, 24'h000740, 24'h01d810, 24'h01231f, 24'h0107d1, 24'h01e39e, 24'h01c09e, 24'h00c48c,
		24'h00c4be, 24'h03e48c, 24'h00209c, 24'h00a794, 24'h0127c2, 24'h01e40e, 24'h00e60e, 24'h01e71e,
		24'h012312, 24'h01ea06, 24'h01679a, 24'h0116c4, 24'h0007c0, 24'h0046d1, 24'h002184, 24'h01f7df
	};

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [X_W-1:0]    col;
		logic [Y_W-1:0]    row;
	} readback_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [CHAR_W-1:0]   ch;
		logic [X_W-1:0]      x;
		logic [Y_W-1:0]      y;
		logic                on;
		logic [BIDX_W-1:0]   bidx;
		logic                typed;
		readback_t           want;
	} directed_row_t;

	// Directed commands at the reset geometry; typed rows carry their own answer
	localparam int DIRECTED_ROWS = 24;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{OP_READ_BYTE,  8'h00, 7'd0,   6'd0,  1'b0, 10'd0,    1'b1, '{8'h00, 7'd0,   6'd0}},
		'{OP_READ_BYTE,  8'h00, 7'd0,   6'd0,  1'b0, 10'd1023, 1'b1, '{8'h00, 7'd0,   6'd0}},
		'{OP_DRAW_CHAR,  8'h41, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_DRAW_CHAR,  8'hff, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_DRAW_CHAR,  8'h7f, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_DRAW_CHAR,  8'h80, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_READ_BYTE,  8'h00, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_READ_BYTE,  8'h00, 7'd0,   6'd0,  1'b0, 10'd5,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_SET_PIXEL,  8'h00, 7'd127, 6'd63, 1'b1, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_READ_BYTE,  8'h00, 7'd0,   6'd0,  1'b0, 10'd1023, 1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_SET_PIXEL,  8'h00, 7'd127, 6'd63, 1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_READ_BYTE,  8'h00, 7'd0,   6'd0,  1'b0, 10'd1023, 1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_SET_CURSOR, 8'h00, 7'd127, 6'd63, 1'b0, 10'd0,    1'b1, '{8'h00, 7'd127, 6'd63}},
		'{OP_DRAW_CHAR,  8'h7f, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_SET_CURSOR, 8'h00, 7'd124, 6'd58, 1'b0, 10'd0,    1'b1, '{8'h00, 7'd124, 6'd58}},
		'{OP_DRAW_CHAR,  8'h57, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_READ_BYTE,  8'h00, 7'd0,   6'd0,  1'b0, 10'd1020, 1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_SPARE_5,    8'h00, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_SPARE_6,    8'hff, 7'd127, 6'd63, 1'b1, 10'd1023, 1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_SPARE_7,    8'hff, 7'd127, 6'd63, 1'b1, 10'd1023, 1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_SET_PIXEL,  8'h00, 7'd0,   6'd0,  1'b1, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_CLEAR,      8'h00, 7'd0,   6'd0,  1'b0, 10'd0,    1'b0, '{8'h00, 7'd0,   6'd0}},
		'{OP_READ_BYTE,  8'h00, 7'd0,   6'd0,  1'b0, 10'd0,    1'b1, '{8'h00, 7'd0,   6'd0}},
		'{OP_SET_CURSOR, 8'h00, 7'd85,  6'd42, 1'b0, 10'd0,    1'b1, '{8'h00, 7'd85,  6'd42}}
	};

	// Geometry of each random phase; the next-to-last one is drawn at random
	localparam logic [CFG_W_W-1:0] PHASE_WIDTH  [PHASES] = '{8'd255, 8'd0, 8'd8, 8'd128,
		8'd37, 8'd100, 8'd0, 8'd128};
	localparam logic [CFG_H_W-1:0] PHASE_HEIGHT [PHASES] = '{7'd127, 7'd0, 7'd8, 7'd64,
		7'd21, 7'd50, 7'd0, 7'd64};
	localparam int QUIET_PHASE = 3;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_we     = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index  = REG_DISPLAY_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data   = '0;
	logic                   start      = 1'b0;
	logic                   busy;
	logic [OPCODE_W-1:0]    opcode     = OP_READ_BYTE;
	logic [CHAR_W-1:0]      char_code  = '0;
	logic [X_W-1:0]         x_coord    = '0;
	logic [Y_W-1:0]         y_coord    = '0;
	logic                   pixel_on   = 1'b0;
	logic [BIDX_W-1:0]      byte_index = '0;
	logic                   done;
	logic [DATA_W-1:0]      read_data;
	logic [X_W-1:0]         cursor_column;
	logic [Y_W-1:0]         cursor_row;

	// Shadow state of the renderer
	logic [7:0]         frame_model [STORE_BYTES];
	int unsigned        cursor_col_m;
	int unsigned        cursor_row_m;
	logic [CFG_W_W-1:0] width_m  = WIDTH_RESET;
	logic [CFG_H_W-1:0] height_m = HEIGHT_RESET;

	readback_t readback_q [$];
	int        fail_count = 0;

	text_framebuffer_renderer #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.char_code    (char_code),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.pixel_on     (pixel_on),
		.byte_index   (byte_index),
		.done         (done),
		.read_data    (read_data),
		.cursor_column(cursor_column),
		.cursor_row   (cursor_row)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned active_width();
		return (width_m > MAX_W) ? MAX_W : width_m;
	endfunction

	function automatic int unsigned active_height();
		return (height_m > MAX_H) ? MAX_H : height_m;
	endfunction

	// Drop pixels that fall off the active screen
	function automatic void plot_pixel(int unsigned px, int unsigned py, logic lit);
		int unsigned w;
		int unsigned idx;
		w = active_width();
		if (px >= w || py >= active_height())
			return;
		idx = px + (py / 8) * w;
		if (idx >= STORE_BYTES)
			return;
		frame_model[idx][py % 8] = lit;
	endfunction

	// Update the shadow state with one command and give its result beat
	function automatic readback_t predict_readback(logic [OPCODE_W-1:0] op,
		logic [CHAR_W-1:0] ch, logic [X_W-1:0] x, logic [Y_W-1:0] y, logic on,
		logic [BIDX_W-1:0] bidx);
		readback_t   beat;
		logic [23:0] bits;
		beat.data = '0;
		case (op)
			OP_DRAW_CHAR: begin
				bits = FONT_BITS[ch[7] ? 7'd0 : ch[6:0]];
				for (int c = 0; c < GLYPH_W; c++)
					for (int r = 0; r < GLYPH_H; r++)
						plot_pixel(cursor_col_m + c, cursor_row_m + r, bits[c * GLYPH_H + r]);
				cursor_col_m += GLYPH_W;
				if (cursor_col_m + GLYPH_W > active_width()) begin
					cursor_col_m = 0;
					cursor_row_m += GLYPH_H;
					if (cursor_row_m + GLYPH_H > active_height())
						cursor_row_m = 0;
				end
				cursor_col_m &= 32'h7f;
				cursor_row_m &= 32'h3f;
			end
			OP_SET_PIXEL: plot_pixel(x, y, on);
			OP_SET_CURSOR: begin
				cursor_col_m = x;
				cursor_row_m = y;
			end
			OP_CLEAR: begin
				foreach (frame_model[i])
					frame_model[i] = '0;
			end
			OP_READ_BYTE: begin
				if (bidx < STORE_BYTES)
					beat.data = frame_model[bidx];
			end
			default: ;
		endcase
		beat.col = cursor_col_m[X_W-1:0];
		beat.row = cursor_row_m[Y_W-1:0];
		return beat;
	endfunction

	// Hold one command on the ports until it is taken, then queue its answer
	task automatic issue_command(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
		input logic [X_W-1:0] x, input logic [Y_W-1:0] y, input logic on,
		input logic [BIDX_W-1:0] bidx, input logic typed, input readback_t typed_want);
		readback_t predicted;
		logic      taken;
		start      <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		x_coord    <= x;
		y_coord    <= y;
		pixel_on   <= on;
		byte_index <= bidx;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		predicted = predict_readback(op, ch, x, y, on, bidx);
		readback_q.push_back(typed ? typed_want : predicted);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Wait until every beat is back and the block is idle
	task automatic drain();
		start <= 1'b0;
		while (readback_q.size() != 0)
			@(posedge clk);
		do
			@(negedge clk);
		while (busy);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DISPLAY_WIDTH)
			width_m = val[CFG_W_W-1:0];
		else
			height_m = val[CFG_H_W-1:0];
	endtask

	// Build one random command, weighted towards text drawing
	task automatic random_command();
		logic [OPCODE_W-1:0] op;
		logic [CHAR_W-1:0]   ch;
		logic [BIDX_W-1:0]   bidx;
		int unsigned         pick;
		int unsigned         w;
		int unsigned         h;
		pick = $urandom_range(0, 99);
		ch   = $urandom_range(0, 255);
		bidx = $urandom_range(0, 1023);
		w    = active_width();
		h    = active_height();
		if (pick < 55) begin
			op = OP_DRAW_CHAR;
			if ($urandom_range(0, 9) < 7)
				ch = $urandom_range(32, 126);
		end else if (pick < 67) begin
			op = OP_SET_PIXEL;
		end else if (pick < 75) begin
			op = OP_SET_CURSOR;
		end else if (pick < 95) begin
			op = OP_READ_BYTE;
			// aim half of the reads at the visible area
			if (w > 0 && h > 0 && $urandom_range(0, 1) == 1)
				bidx = $urandom_range(0, w - 1) + $urandom_range(0, (h - 1) / 8) * w;
		end else if (pick < 96) begin
			op = OP_CLEAR;
		end else begin
			op = $urandom_range(OP_SPARE_5, OP_SPARE_7);
		end
		issue_command(op, ch, $urandom_range(0, 127), $urandom_range(0, 63),
			$urandom_range(0, 1), bidx, 1'b0, '0);
	endtask

	// Check each result beat against the oldest pending answer
	always @(negedge clk) begin
		readback_t want;
		if (arst_n && done) begin
			if (readback_q.size() == 0) begin
				$error("result beat with nothing pending: read_data %0h column %0d row %0d",
					read_data, cursor_column, cursor_row);
				fail_count++;
			end else begin
				want = readback_q.pop_front();
				if (read_data !== want.data) begin
					$error("read_data: expected %0h, got %0h", want.data, read_data);
					fail_count++;
				end
				if (cursor_column !== want.col) begin
					$error("cursor_column: expected %0d, got %0d", want.col, cursor_column);
					fail_count++;
				end
				if (cursor_row !== want.row) begin
					$error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
					fail_count++;
				end
			end
		end
	end

	initial begin
		foreach (frame_model[i])
			frame_model[i] = '0;
		cursor_col_m = 0;
		cursor_row_m = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table at the reset geometry
		foreach (DIRECTED[i]) begin
			if ($urandom_range(0, 99) < 8)
				pause_sender($urandom_range(1, 24));
			issue_command(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].x, DIRECTED[i].y,
				DIRECTED[i].on, DIRECTED[i].bidx, DIRECTED[i].typed, DIRECTED[i].want);
		end

		// Random phases, one geometry each, reprogrammed only while idle
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == PHASES - 2) begin
				write_reg(REG_DISPLAY_WIDTH, $urandom_range(0, 255));
				write_reg(REG_DISPLAY_HEIGHT, $urandom_range(0, 127));
			end else begin
				write_reg(REG_DISPLAY_WIDTH, PHASE_WIDTH[p]);
				write_reg(REG_DISPLAY_HEIGHT, PHASE_HEIGHT[p]);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p != QUIET_PHASE && $urandom_range(0, 99) < 8)
					pause_sender($urandom_range(1, 24));
				random_command();
			end
		end

		// Let the last beats come back, then watch for stray ones
		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end

endmodule
